// ===== sv/klt_pkg.sv =====
// key lifecycle table: shared types, codes and sizes
// used by klt_entry_mem and key_lifecycle_table_core
`timescale 1ns / 1ps
`default_nettype none
package klt_pkg;

  localparam int unsigned CAPACITY_DEF = 64;
  localparam logic [15:0] LIMIT_RST = 16'd4096;

  typedef enum logic [2:0] {
    OP_INSERT  = 3'd0,
    OP_LOOKUP  = 3'd1,
    OP_LOOKCUR = 3'd2,
    OP_NEXTID  = 3'd3,
    OP_ROTATE  = 3'd4,
    OP_MARK    = 3'd5,
    OP_PRUNE   = 3'd6,
    OP_COMMIT  = 3'd7
  } op_t;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_INVAL   = 3'd1,
    ST_RANGE   = 3'd2,
    ST_NOENT   = 3'd3,
    ST_CORRUPT = 3'd4,
    ST_FULL    = 3'd5
  } status_t;

  localparam logic [1:0] LC_CURRENT = 2'd0;
  localparam logic [1:0] LC_RETIRED = 2'd1;
  localparam logic [1:0] LC_PRUNING = 2'd2;

  typedef struct packed {
    logic [63:0] dataset;
    logic [63:0] key_id;
    logic [1:0]  lc;
    logic [15:0] wlen;
  } entry_t;

endpackage
`default_nettype wire

// ===== sv/klt_entry_mem.sv =====
// key lifecycle table: entry memory, one write and one registered read port
// depends on klt_pkg
`timescale 1ns / 1ps
`default_nettype none
module klt_entry_mem #(
  parameter int unsigned CAPACITY = klt_pkg::CAPACITY_DEF,
  parameter int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1
) (
  input  wire logic            clk,
  input  wire logic            wr_en,
  input  wire logic [AW-1:0]   wr_addr,
  input  wire klt_pkg::entry_t wr_data,
  input  wire logic [AW-1:0]   rd_addr,
  output klt_pkg::entry_t      rd_data_r
);

  klt_pkg::entry_t mem [CAPACITY];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

endmodule
`default_nettype wire

// ===== sv/key_lifecycle_table_core.sv =====
// key lifecycle table top: scan engine, decision and write-back over the entry memory
// sequence: accept, scan of every held entry, decision and write, result register;
//   rotate then retires the old current entry, prune moves the last entry to the freed slot
// one request at a time; next accepted once the result is registered, later if one is held
// reset: count 0, dirty 1, wrapped limit 4096; memory content is not cleared
// depends on klt_pkg and klt_entry_mem
`timescale 1ns / 1ps
`default_nettype none
module key_lifecycle_table_core #(
  parameter int unsigned CAPACITY = klt_pkg::CAPACITY_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_wr_en,
  input  wire logic [15:0] cfg_wr_data,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [2:0]  in_op,
  input  wire logic [63:0] in_dataset,
  input  wire logic [63:0] in_key_id,
  input  wire logic [1:0]  in_entry_state,
  input  wire logic [15:0] in_wrapped_len,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [2:0]       out_status,
  output logic [1:0]       out_state_out,
  output logic [63:0]      out_key_id_out,
  output logic [15:0]      out_wrapped_len_out,
  output logic [6:0]       out_entry_count,
  output logic             out_dirty_out
);

  localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CW = $clog2(CAPACITY + 1);

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_SCAN   = 7'b0000010,
    S_DECIDE = 7'b0000100,
    S_WR2    = 7'b0001000,
    S_RDL    = 7'b0010000,
    S_MV     = 7'b0100000,
    S_DONE   = 7'b1000000
  } fsm_t;

  fsm_t state_r, state_nxt;
  logic [15:0] limit_r;
  logic [CW-1:0] cnt_r, cnt_nxt, issue_r, issue_nxt;
  logic dirty_r, dirty_nxt;
  logic pend_r, pend_nxt;
  logic [AW-1:0] pend_idx_r;

  klt_pkg::op_t op_r;
  logic [63:0] ds_r, kid_r;
  logic [1:0] est_r;
  logic [15:0] wlen_r;

  logic ex_hit_r, ex_hit_nxt;
  logic [AW-1:0] ex_slot_r, ex_slot_nxt;
  logic [1:0] ex_st_r, ex_st_nxt;
  logic [15:0] ex_len_r, ex_len_nxt;
  logic [1:0] cur_n_r, cur_n_nxt;
  logic [AW-1:0] cur_slot_r, cur_slot_nxt;
  logic [63:0] cur_key_r, cur_key_nxt;
  logic [15:0] cur_len_r, cur_len_nxt;
  logic any_r, any_nxt;
  logic [63:0] best_r, best_nxt;

  klt_pkg::status_t res_st_r, res_st_nxt;
  logic [1:0] res_lc_r, res_lc_nxt;
  logic [63:0] res_key_r, res_key_nxt;
  logic [15:0] res_len_r, res_len_nxt;

  logic out_valid_r;
  klt_pkg::status_t o_st_r;
  logic [1:0] o_lc_r;
  logic [63:0] o_key_r;
  logic [15:0] o_len_r;
  logic [6:0] o_cnt_r;
  logic o_dirty_r;

  logic wr_en;
  logic [AW-1:0] wr_addr, rd_addr;
  klt_pkg::entry_t wr_data, rd_data_r;

  logic [63:0] nx;
  logic nx_rng, full;

  klt_entry_mem #(.CAPACITY(CAPACITY), .AW(AW)) u_mem (
    .clk(clk), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data),
    .rd_addr(rd_addr), .rd_data_r(rd_data_r)
  );

  assign in_ready = (state_r == S_IDLE);
  assign nx = any_r ? best_r + 64'd1 : 64'd0;
  assign nx_rng = any_r && (best_r == '1);
  assign full = (cnt_r == CW'(CAPACITY));
  assign rd_addr = (state_r == S_RDL) ? cnt_r[AW-1:0] : issue_r[AW-1:0];

  always_comb begin
    state_nxt = state_r;
    cnt_nxt = cnt_r;
    issue_nxt = issue_r;
    dirty_nxt = dirty_r;
    pend_nxt = 1'b0;
    ex_hit_nxt = ex_hit_r;
    ex_slot_nxt = ex_slot_r;
    ex_st_nxt = ex_st_r;
    ex_len_nxt = ex_len_r;
    cur_n_nxt = cur_n_r;
    cur_slot_nxt = cur_slot_r;
    cur_key_nxt = cur_key_r;
    cur_len_nxt = cur_len_r;
    any_nxt = any_r;
    best_nxt = best_r;
    res_st_nxt = res_st_r;
    res_lc_nxt = res_lc_r;
    res_key_nxt = res_key_r;
    res_len_nxt = res_len_r;
    wr_en = 1'b0;
    wr_addr = ex_slot_r;
    wr_data = '{dataset: ds_r, key_id: kid_r, lc: klt_pkg::LC_CURRENT, wlen: wlen_r};
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = S_SCAN;
          issue_nxt = '0;
          ex_hit_nxt = 1'b0;
          cur_n_nxt = 2'd0;
          any_nxt = 1'b0;
          best_nxt = '0;
        end
      end
      S_SCAN: begin
        if (issue_r < cnt_r) begin
          pend_nxt = 1'b1;
          issue_nxt = issue_r + CW'(1);
        end else if (!pend_r) begin
          state_nxt = S_DECIDE;
        end
        if (pend_r && rd_data_r.dataset == ds_r) begin
          if (rd_data_r.key_id == kid_r && !ex_hit_r) begin
            ex_hit_nxt = 1'b1;
            ex_slot_nxt = pend_idx_r;
            ex_st_nxt = rd_data_r.lc;
            ex_len_nxt = rd_data_r.wlen;
          end
          if (rd_data_r.lc == klt_pkg::LC_CURRENT) begin
            if (cur_n_r != 2'd2) begin
              cur_n_nxt = cur_n_r + 2'd1;
            end
            cur_slot_nxt = pend_idx_r;
            cur_key_nxt = rd_data_r.key_id;
            cur_len_nxt = rd_data_r.wlen;
          end
          if (!any_r || rd_data_r.key_id > best_r) begin
            best_nxt = rd_data_r.key_id;
          end
          any_nxt = 1'b1;
        end
      end
      S_DECIDE: begin
        state_nxt = S_DONE;
        res_st_nxt = klt_pkg::ST_OK;
        res_lc_nxt = '0;
        res_key_nxt = '0;
        res_len_nxt = '0;
        case (op_r)
          klt_pkg::OP_INSERT: begin
            if (wlen_r > limit_r) begin
              res_st_nxt = klt_pkg::ST_RANGE;
            end else if (est_r != klt_pkg::LC_CURRENT) begin
              res_st_nxt = klt_pkg::ST_INVAL;
            end else if (ex_hit_r) begin
              wr_en = 1'b1;
              dirty_nxt = 1'b1;
            end else if (full) begin
              res_st_nxt = klt_pkg::ST_FULL;
            end else begin
              wr_en = 1'b1;
              wr_addr = cnt_r[AW-1:0];
              cnt_nxt = cnt_r + CW'(1);
              dirty_nxt = 1'b1;
            end
          end
          klt_pkg::OP_LOOKUP: begin
            if (!ex_hit_r) begin
              res_st_nxt = klt_pkg::ST_NOENT;
            end else begin
              res_lc_nxt = ex_st_r;
              res_len_nxt = ex_len_r;
            end
          end
          klt_pkg::OP_LOOKCUR: begin
            if (cur_n_r > 2'd1) begin
              res_st_nxt = klt_pkg::ST_CORRUPT;
            end else if (cur_n_r == 2'd0) begin
              res_st_nxt = klt_pkg::ST_NOENT;
            end else begin
              res_key_nxt = cur_key_r;
              res_len_nxt = cur_len_r;
            end
          end
          klt_pkg::OP_NEXTID: begin
            if (nx_rng) begin
              res_st_nxt = klt_pkg::ST_RANGE;
            end else begin
              res_key_nxt = nx;
            end
          end
          klt_pkg::OP_ROTATE: begin
            if (wlen_r == 16'd0) begin
              res_st_nxt = klt_pkg::ST_INVAL;
            end else if (wlen_r > limit_r || nx_rng) begin
              res_st_nxt = klt_pkg::ST_RANGE;
            end else if (kid_r != nx) begin
              res_st_nxt = klt_pkg::ST_INVAL;
            end else if (cur_n_r > 2'd1) begin
              res_st_nxt = klt_pkg::ST_CORRUPT;
            end else if (cur_n_r == 2'd0) begin
              res_st_nxt = klt_pkg::ST_NOENT;
            end else if (ex_hit_r) begin
              res_st_nxt = klt_pkg::ST_CORRUPT;
            end else if (full) begin
              res_st_nxt = klt_pkg::ST_FULL;
            end else begin
              wr_en = 1'b1;
              wr_addr = cnt_r[AW-1:0];
              cnt_nxt = cnt_r + CW'(1);
              dirty_nxt = 1'b1;
              res_key_nxt = cur_key_r;
              res_lc_nxt = klt_pkg::LC_RETIRED;
              state_nxt = S_WR2;
            end
          end
          klt_pkg::OP_MARK: begin
            if (!ex_hit_r) begin
              res_st_nxt = klt_pkg::ST_NOENT;
            end else if (ex_st_r != klt_pkg::LC_RETIRED) begin
              res_st_nxt = klt_pkg::ST_INVAL;
            end else begin
              wr_en = 1'b1;
              wr_data.lc = klt_pkg::LC_PRUNING;
              wr_data.wlen = ex_len_r;
              dirty_nxt = 1'b1;
              res_lc_nxt = klt_pkg::LC_PRUNING;
            end
          end
          klt_pkg::OP_PRUNE: begin
            if (!ex_hit_r) begin
              res_st_nxt = klt_pkg::ST_NOENT;
            end else if (ex_st_r != klt_pkg::LC_PRUNING) begin
              res_st_nxt = klt_pkg::ST_INVAL;
            end else begin
              cnt_nxt = cnt_r - CW'(1);
              dirty_nxt = 1'b1;
              state_nxt = S_RDL;
            end
          end
          default: begin
            dirty_nxt = 1'b0;
          end
        endcase
      end
      S_WR2: begin
        // retire the old current entry
        wr_en = 1'b1;
        wr_addr = cur_slot_r;
        wr_data = '{dataset: ds_r, key_id: cur_key_r, lc: klt_pkg::LC_RETIRED,
                    wlen: cur_len_r};
        state_nxt = S_DONE;
      end
      S_RDL: begin
        state_nxt = S_MV;
      end
      S_MV: begin
        // last entry fills the freed slot
        wr_en = 1'b1;
        wr_data = rd_data_r;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r <= '0;
      dirty_r <= 1'b1;
      limit_r <= klt_pkg::LIMIT_RST;
      pend_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r <= cnt_nxt;
      dirty_r <= dirty_nxt;
      pend_r <= pend_nxt;
      if (cfg_wr_en) begin
        limit_r <= cfg_wr_data;
      end
      if (state_r == S_DONE && (!out_valid_r || out_ready)) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    issue_r <= issue_nxt;
    pend_idx_r <= issue_r[AW-1:0];
    ex_hit_r <= ex_hit_nxt;
    ex_slot_r <= ex_slot_nxt;
    ex_st_r <= ex_st_nxt;
    ex_len_r <= ex_len_nxt;
    cur_n_r <= cur_n_nxt;
    cur_slot_r <= cur_slot_nxt;
    cur_key_r <= cur_key_nxt;
    cur_len_r <= cur_len_nxt;
    any_r <= any_nxt;
    best_r <= best_nxt;
    res_st_r <= res_st_nxt;
    res_lc_r <= res_lc_nxt;
    res_key_r <= res_key_nxt;
    res_len_r <= res_len_nxt;
    if (in_valid && in_ready) begin
      op_r <= klt_pkg::op_t'(in_op);
      ds_r <= in_dataset;
      kid_r <= in_key_id;
      est_r <= in_entry_state;
      wlen_r <= in_wrapped_len;
    end
    if (state_r == S_DONE && (!out_valid_r || out_ready)) begin
      o_st_r <= res_st_r;
      o_lc_r <= res_lc_r;
      o_key_r <= res_key_r;
      o_len_r <= res_len_r;
      o_cnt_r <= 7'(cnt_r);
      o_dirty_r <= dirty_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_status = o_st_r;
  assign out_state_out = o_lc_r;
  assign out_key_id_out = o_key_r;
  assign out_wrapped_len_out = o_len_r;
  assign out_entry_count = o_cnt_r;
  assign out_dirty_out = o_dirty_r;

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(CAPACITY)) else $error("entry count above capacity");
  a_accept_scan: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> state_r == S_SCAN) else $error("accept did not start scan");
  a_wr_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> {1'b0, wr_addr} <= (AW+1)'(cnt_r)) else $error("write beyond held entries");
  a_pend_scan: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r |-> state_r == S_SCAN) else $error("read data pending outside scan");
`endif

endmodule
`default_nettype wire
